// ===== rtl/mpt_pkg.sv =====
// Shared types and constants for the mouse packet cursor tracker.
package mpt_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd1;

  // Field widths
  localparam int unsigned X_W     = 9;
  localparam int unsigned Y_W     = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned ACC_W   = 10;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned CFG_W   = 9;

  // Reset values
  localparam logic [X_W-1:0] MAX_X_RST = 9'd309;
  localparam logic [Y_W-1:0] MAX_Y_RST = 8'd224;
  localparam logic [X_W-1:0] POS_X_RST = 9'd160;
  localparam logic [Y_W-1:0] POS_Y_RST = 8'd120;

  // Flag byte bit positions
  localparam int unsigned FLAG_LEFT  = 0;
  localparam int unsigned FLAG_SYNC  = 3;
  localparam int unsigned FLAG_XSIGN = 4;
  localparam int unsigned FLAG_YSIGN = 5;
  localparam int unsigned FLAG_XOVF  = 6;
  localparam int unsigned FLAG_YOVF  = 7;

  // One decoded packet result
  typedef struct packed {
    logic [X_W-1:0]   cursor_x;
    logic [Y_W-1:0]   cursor_y;
    logic             left_button;
    logic             click_event;
    logic             dot_stored;
    logic [CNT_W-1:0] dot_count;
    logic             packet_dropped;
  } result_t;

endpackage

// ===== rtl/mpt_if.sv =====
// Channel interfaces: mouse byte stream, packet results and configuration writes.
interface mpt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpt_result_if;
  logic             valid;
  logic             ready;
  mpt_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mpt_pkg::CFG_IDX_W-1:0]   reg_idx;
  logic [mpt_pkg::CFG_W-1:0]       wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

// ===== rtl/mouse_packet_cursor_tracker_core.sv =====
// Top level of the mouse packet cursor tracker.
//
// Channels: rx_i carries one PS/2 mouse byte per transaction; res_o carries
// one result per completed three-byte packet (flags, X delta, Y delta);
// cfg_i writes the cursor limits max_x (index 0) and max_y (index 1) and is
// always ready. A flags byte without bit 3 set is dropped while waiting for
// packet start.
// Latency: the result of a packet is registered at the edge that accepts
// its third byte and is offered on res_o from the next cycle.
// Throughput: one byte per cycle; all packet math is a single combinational
// pass from the held packet state and the incoming third byte to the result
// register, and the result register refills in the same cycle it is taken.
// When res_o stalls, the held result stays put and rx_i ready drops until
// the result is taken.
// Reset: packet assembly restarts, cursor goes to (160, 120), remainders,
// button history and dot count clear, limits return to 309 and 224.
module mouse_packet_cursor_tracker_core #(
  parameter int unsigned SPEED_DIVISOR = 2,
  parameter int unsigned DOT_CAPACITY  = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpt_byte_if.sink     rx_i,
  mpt_result_if.source res_o,
  mpt_cfg_if.sink      cfg_i
);
  import mpt_pkg::*;

  localparam int unsigned DOTS_W = $clog2(DOT_CAPACITY + 1);
  localparam logic [DOTS_W-1:0] DOT_CAP_L = DOTS_W'(DOT_CAPACITY);

  // Byte position codes
  localparam logic [1:0] BP_FLAGS = 2'd0;
  localparam logic [1:0] BP_DX    = 2'd1;
  localparam logic [1:0] BP_DY    = 2'd2;

  logic [X_W-1:0]          max_x_q;
  logic [Y_W-1:0]          max_y_q;
  logic [1:0]              bpos_q, bpos_d;
  logic [7:0]              flags_q;
  logic [7:0]              dx_q;
  logic signed [ACC_W-1:0] accx_q, accy_q;
  logic signed [ACC_W-1:0] accx_new, accy_new;
  logic [X_W-1:0]          curx_q, curx_new;
  logic [Y_W-1:0]          cury_q, cury_new;
  logic                    prev_btn_q;
  logic [DOTS_W-1:0]       dots_q, dots_d;
  logic                    out_valid_q;
  result_t                 out_q, res_d;

  logic                    in_fire;
  logic                    last_byte;
  logic                    ovf;
  logic                    click;
  logic                    stored;
  logic signed [DELTA_W-1:0] dx, dy;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= MAX_X_RST;
      max_y_q <= MAX_Y_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        REG_MAX_X: max_x_q <= cfg_i.wdata[X_W-1:0];
        REG_MAX_Y: max_y_q <= cfg_i.wdata[Y_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a byte whenever the result register is free or draining
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign last_byte  = in_fire && (bpos_q == BP_DY);

  // Advance packet assembly
  always_comb begin
    bpos_d = bpos_q;
    unique case (bpos_q)
      BP_FLAGS: if (rx_i.rx_byte[FLAG_SYNC]) bpos_d = BP_DX;
      BP_DX:    bpos_d = BP_DY;
      BP_DY:    bpos_d = BP_FLAGS;
      default:  bpos_d = BP_FLAGS;
    endcase
  end

  // Sign-extend deltas from the flag bits
  assign dx  = {flags_q[FLAG_XSIGN], dx_q};
  assign dy  = {flags_q[FLAG_YSIGN], rx_i.rx_byte};
  assign ovf = flags_q[FLAG_XOVF] || flags_q[FLAG_YOVF];

  mpt_axis_step #(
    .POS_W  (X_W),
    .DIVISOR(SPEED_DIVISOR),
    .INVERT (1'b0)
  ) u_axis_x (
    .accum_i(accx_q),
    .delta_i(dx),
    .pos_i  (curx_q),
    .max_i  (max_x_q),
    .accum_o(accx_new),
    .pos_o  (curx_new)
  );

  mpt_axis_step #(
    .POS_W  (Y_W),
    .DIVISOR(SPEED_DIVISOR),
    .INVERT (1'b1)
  ) u_axis_y (
    .accum_i(accy_q),
    .delta_i(dy),
    .pos_i  (cury_q),
    .max_i  (max_y_q),
    .accum_o(accy_new),
    .pos_o  (cury_new)
  );

  // Detect a click and count it while capacity remains
  assign click  = flags_q[FLAG_LEFT] && !prev_btn_q && !ovf;
  assign stored = click && (dots_q < DOT_CAP_L);
  assign dots_d = stored ? dots_q + DOTS_W'(1) : dots_q;

  // Build the result of a completed packet
  always_comb begin
    res_d.cursor_x       = ovf ? curx_q : curx_new;
    res_d.cursor_y       = ovf ? cury_q : cury_new;
    res_d.left_button    = flags_q[FLAG_LEFT];
    res_d.click_event    = click;
    res_d.dot_stored     = stored;
    res_d.dot_count      = CNT_W'(dots_d);
    res_d.packet_dropped = ovf;
  end

  // Hold packet and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q     <= BP_FLAGS;
      flags_q    <= '0;
      dx_q       <= '0;
      accx_q     <= '0;
      accy_q     <= '0;
      curx_q     <= POS_X_RST;
      cury_q     <= POS_Y_RST;
      prev_btn_q <= 1'b0;
      dots_q     <= '0;
    end else if (in_fire) begin
      bpos_q <= bpos_d;
      if (bpos_q == BP_FLAGS && rx_i.rx_byte[FLAG_SYNC]) begin
        flags_q <= rx_i.rx_byte;
      end
      if (bpos_q == BP_DX) begin
        dx_q <= rx_i.rx_byte;
      end
      if (bpos_q == BP_DY) begin
        prev_btn_q <= flags_q[FLAG_LEFT];
        if (!ovf) begin
          accx_q <= accx_new;
          accy_q <= accy_new;
          curx_q <= curx_new;
          cury_q <= cury_new;
          dots_q <= dots_d;
        end
      end
    end
  end

  // Result register: load on packet end, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_byte) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_byte) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // A new result only follows the third byte of a packet
  a_result_after_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_byte))
    else $error("result appeared without a completed packet");

  // Stored dot count never passes capacity
  a_dots_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dots_q <= DOT_CAP_L)
    else $error("dot count exceeded capacity");

  // A dropped packet carries no click and stores no dot
  a_drop_no_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.packet_dropped) |-> (!out_q.click_event && !out_q.dot_stored))
    else $error("dropped packet reported a click");

  // The dot count only moves on the last byte of a valid packet
  a_dots_move_on_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dots_q != $past(dots_q)) |-> $past(last_byte && !ovf))
    else $error("dot count changed outside a valid packet");

endmodule

// ===== rtl/mpt_axis_step.sv =====
// One cursor axis: accumulate delta, divide toward zero, move and clamp.
module mpt_axis_step #(
  parameter int unsigned POS_W   = 9,
  parameter int unsigned DIVISOR = 2,
  parameter bit          INVERT  = 1'b0
) (
  input  logic signed [mpt_pkg::ACC_W-1:0]   accum_i,
  input  logic signed [mpt_pkg::DELTA_W-1:0] delta_i,
  input  logic        [POS_W-1:0]            pos_i,
  input  logic        [POS_W-1:0]            max_i,
  output logic signed [mpt_pkg::ACC_W-1:0]   accum_o,
  output logic        [POS_W-1:0]            pos_o
);
  import mpt_pkg::*;

  localparam int unsigned SUM_W  = ACC_W + 1;
  localparam int unsigned MAG_W  = ACC_W;
  localparam int unsigned RSHIFT = 16;
  // ceil(2^16 / DIVISOR): exact floor for magnitudes below 2^10
  localparam int unsigned RECIP  = ((1 << RSHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned RCP_W  = RSHIFT + 1;
  localparam int unsigned PROD_W = MAG_W + RCP_W;
  localparam int unsigned DIV_W  = 4;
  localparam int unsigned QT_W   = MAG_W + DIV_W;
  localparam int unsigned POSX_W = 12;

  localparam logic [RCP_W-1:0] RECIP_L = RCP_W'(RECIP);
  localparam logic [DIV_W-1:0] DIV_L   = DIV_W'(DIVISOR);

  logic signed [SUM_W-1:0]       sum;
  logic                          neg;
  logic        [MAG_W-1:0]       mag;
  logic        [PROD_W-1:0]      prod;
  logic        [MAG_W-1:0]       quo_mag;
  logic        [QT_W-1:0]        quo_times;
  logic        [MAG_W-1:0]       rem_mag;
  logic signed [SUM_W-1:0]       quo;
  logic signed [POSX_W-1:0]      base;
  logic signed [POSX_W-1:0]      step;
  logic signed [POSX_W-1:0]      moved;
  logic signed [POSX_W-1:0]      lim;

  // Add delta to the sub-pixel remainder
  assign sum = SUM_W'(accum_i) + SUM_W'(delta_i);
  assign neg = sum[SUM_W-1];
  assign mag = neg ? MAG_W'(-sum) : MAG_W'(sum);

  // Divide the magnitude by reciprocal multiply, then restore the sign
  assign prod      = PROD_W'(mag) * PROD_W'(RECIP_L);
  assign quo_mag   = prod[RSHIFT +: MAG_W];
  assign quo_times = QT_W'(quo_mag) * QT_W'(DIV_L);
  assign rem_mag   = mag - quo_times[MAG_W-1:0];
  assign quo       = neg ? -SUM_W'(quo_mag) : SUM_W'(quo_mag);
  assign accum_o   = neg ? -ACC_W'(rem_mag) : ACC_W'(rem_mag);

  // Move and clamp to [0, max]
  assign base  = POSX_W'(pos_i);
  assign step  = POSX_W'(quo);
  assign moved = INVERT ? (base - step) : (base + step);
  assign lim   = POSX_W'(max_i);

  always_comb begin
    if (moved < 0) begin
      pos_o = '0;
    end else if (moved > lim) begin
      pos_o = max_i;
    end else begin
      pos_o = moved[POS_W-1:0];
    end
  end

endmodule

// ===== dv/mpt_packet_checker.sv =====
// Checker for the mouse packet cursor tracker: watches the channels, predicts packets, compares.
`timescale 1ns / 1ps

module mpt_packet_checker #(
  parameter int unsigned SPEED_DIVISOR = 2,
  parameter int unsigned DOT_CAPACITY  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  input  logic                          rx_ready_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  mpt_pkg::result_t              res_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mpt_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int unsigned                   error_count_o,
  output int unsigned                   pending_o
);
  import mpt_pkg::*;

  // Cursor limits as last written
  logic [X_W-1:0] limit_x = MAX_X_RST;
  logic [Y_W-1:0] limit_y = MAX_Y_RST;

  // Packet assembly and tracking state
  logic [1:0]  pkt_pos   = '0;
  logic [7:0]  pkt_flags = '0;
  logic [7:0]  pkt_dx    = '0;
  int          rem_x     = 0;
  int          rem_y     = 0;
  int          cur_x     = int'(POS_X_RST);
  int          cur_y     = int'(POS_Y_RST);
  logic        last_left = 1'b0;
  int unsigned dots      = 0;

  result_t     packets_due[$];
  int unsigned errors = 0;

  assign error_count_o = errors;

  task automatic report_mismatch(input string msg);
    $display("%0t mpt_packet_checker: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance packet assembly by one byte; queue the result of a completed packet
  function automatic void decode_mouse_byte(input logic [7:0] b);
    int      dx;
    int      dy;
    int      sx;
    int      sy;
    int      mx;
    int      my;
    result_t r;
    case (pkt_pos)
      2'd0: begin
        // Drop bytes without the sync bit while waiting for packet start
        if (b[FLAG_SYNC]) begin
          pkt_flags = b;
          pkt_pos   = 2'd1;
        end
      end
      2'd1: begin
        pkt_dx  = b;
        pkt_pos = 2'd2;
      end
      default: begin
        pkt_pos = 2'd0;
        r = '0;
        r.left_button = pkt_flags[FLAG_LEFT];
        if (pkt_flags[FLAG_XOVF] || pkt_flags[FLAG_YOVF]) begin
          // Overflow: discard motion, keep remainders and count, report cursor as is
          r.packet_dropped = 1'b1;
        end else begin
          dx = pkt_flags[FLAG_XSIGN] ? int'(pkt_dx) - 256 : int'(pkt_dx);
          dy = pkt_flags[FLAG_YSIGN] ? int'(b) - 256 : int'(b);
          sx = rem_x + dx;
          sy = rem_y + dy;
          mx = sx / int'(SPEED_DIVISOR);
          my = sy / int'(SPEED_DIVISOR);
          rem_x = sx - mx * int'(SPEED_DIVISOR);
          rem_y = sy - my * int'(SPEED_DIVISOR);
          // Screen Y grows downward
          cur_x = clamp_to(cur_x + mx, int'(limit_x));
          cur_y = clamp_to(cur_y - my, int'(limit_y));
          if (pkt_flags[FLAG_LEFT] && !last_left) begin
            r.click_event = 1'b1;
            if (dots < DOT_CAPACITY) begin
              dots++;
              r.dot_stored = 1'b1;
            end
          end
        end
        last_left   = pkt_flags[FLAG_LEFT];
        r.cursor_x  = cur_x[X_W-1:0];
        r.cursor_y  = cur_y[Y_W-1:0];
        r.dot_count = dots[CNT_W-1:0];
        packets_due.push_back(r);
      end
    endcase
  endfunction

  // Compare one received result against the oldest prediction
  task automatic check_packet(input result_t got);
    result_t want;
    if (packets_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: x %0d y %0d",
                                got.cursor_x, got.cursor_y));
    end else begin
      want = packets_due.pop_front();
      check_field("cursor_x", got.cursor_x, want.cursor_x);
      check_field("cursor_y", got.cursor_y, want.cursor_y);
      check_field("left_button", got.left_button, want.left_button);
      check_field("click_event", got.click_event, want.click_event);
      check_field("dot_stored", got.dot_stored, want.dot_stored);
      check_field("dot_count", got.dot_count, want.dot_count);
      check_field("packet_dropped", got.packet_dropped, want.packet_dropped);
    end
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_x   = MAX_X_RST;
      limit_y   = MAX_Y_RST;
      pkt_pos   = '0;
      pkt_flags = '0;
      pkt_dx    = '0;
      rem_x     = 0;
      rem_y     = 0;
      cur_x     = int'(POS_X_RST);
      cur_y     = int'(POS_Y_RST);
      last_left = 1'b0;
      dots      = 0;
      packets_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          REG_MAX_X: limit_x = cfg_wdata_i[X_W-1:0];
          REG_MAX_Y: limit_y = cfg_wdata_i[Y_W-1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) check_packet(res_data_i);
      if (rx_valid_i && rx_ready_i) decode_mouse_byte(rx_byte_i);
      pending_o <= packets_due.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the mouse packet cursor tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // Index that maps to no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          calm = 1'b0;
  logic        last_left = 1'b0;
  int unsigned cycles = 0;
  int unsigned error_count;
  int unsigned pending;

  mpt_byte_if   rx_if ();
  mpt_result_if res_if ();
  mpt_cfg_if    cfg_if ();

  mouse_packet_cursor_tracker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  mpt_packet_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_if.valid),
    .rx_ready_i    (rx_if.ready),
    .rx_byte_i     (rx_if.rx_byte),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_data_i    (res_if.data),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_idx_i     (cfg_if.reg_idx),
    .cfg_wdata_i   (cfg_if.wdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always #6 clk_i = ~clk_i;

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Stall the result channel at random, except during calm stretches
  always @(posedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(99) >= 24);
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        rx_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
  endtask

  task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(flags);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Hold the stream until every predicted packet has come back
  task automatic drain();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y);
    cfg_write(REG_MAX_X, x);
    cfg_write(REG_MAX_Y, y);
    cfg_if.valid <= 1'b0;
  endtask

  // Mix of large and small deltas in 9-bit two's complement
  function automatic logic [8:0] pick_delta();
    logic [8:0] d;
    if ($urandom_range(1) != 0) begin
      d = 9'($urandom);
    end else begin
      d = 9'($urandom_range(12));
      if ($urandom_range(1) != 0) d = -d;
    end
    return d;
  endfunction

  // Send well-formed packets with random content, some overflow packets and stray
  // bytes; with toggle set the left button flips almost every packet to force clicks
  task automatic send_motion(input int unsigned n, input bit toggle);
    int unsigned kind;
    logic [7:0]  flags;
    logic [8:0]  dx;
    logic [8:0]  dy;
    for (int unsigned i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        flags = 8'($urandom);
        flags[FLAG_SYNC] = 1'b0;
        send_byte(flags);
      end
      flags = 8'($urandom);
      flags[FLAG_SYNC] = 1'b1;
      flags[FLAG_XOVF] = 1'b0;
      flags[FLAG_YOVF] = 1'b0;
      if (kind >= 6 && kind < 14) flags[FLAG_XOVF + $urandom_range(1)] = 1'b1;
      if (toggle) flags[FLAG_LEFT] = ($urandom_range(99) < 95) ? ~last_left : last_left;
      last_left = flags[FLAG_LEFT];
      dx = pick_delta();
      dy = pick_delta();
      flags[FLAG_XSIGN] = dx[8];
      flags[FLAG_YSIGN] = dy[8];
      send_packet(flags, dx[7:0], dy[7:0]);
    end
    drain();
  endtask

  initial begin
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.reg_idx <= REG_MAX_X;
    cfg_if.wdata   <= '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unmapped index first, then the reset limits
    cfg_write(REG_SPARE, '1);
    set_limits(CFG_W'(MAX_X_RST), CFG_W'(MAX_Y_RST));

    // Directed: bytes without sync, zero motion, full-scale deltas, overflow packets
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h09, 8'hFF, 8'hFF);
    send_packet(8'h39, 8'h01, 8'h01);
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'h48, 8'h10, 8'h10);
    // Overflow press records the button, so the next valid press is no click
    send_packet(8'hC9, 8'hAA, 8'h55);
    send_packet(8'h0F, 8'h03, 8'h05);
    send_packet(8'h8E, 8'h20, 8'h20);
    last_left = 1'b0;
    drain();

    // Limits below the cursor: overflow packet reports it unclamped, then clamp
    set_limits('0, '0);
    send_packet(8'hC8, 8'h7F, 8'h80);
    send_motion(40, 1'b0);

    // Widest limits, upper bit of the Y write masked off; no idling
    set_limits('1, '1);
    calm = 1'b1;
    send_motion(100, 1'b1);
    calm = 1'b0;

    set_limits(9'd1, 9'd1);
    send_motion(25, 1'b0);

    set_limits(9'($urandom_range(511)), 9'($urandom_range(511)));
    send_motion(60, 1'b0);

    // Click-heavy run to build up the dot count
    set_limits(CFG_W'(MAX_X_RST), CFG_W'(MAX_Y_RST));
    send_motion(140, 1'b1);

    set_limits(9'($urandom_range(20, 60)), 9'($urandom_range(10, 40)));
    send_motion(75, 1'b1);

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
